### rtl/core/ser_pkg.sv
// Shared types, constants and coefficient tables for the stereo early-reflection block.
// No dependencies; every other file in rtl/core imports this package.
package ser_pkg;

    localparam int TAP_COUNT   = 7;
    localparam int TAP_W       = 3;
    localparam int SAMPLE_W    = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;
    localparam int RATE_W      = 17;
    localparam int ROOM_W      = 10;
    localparam int COEF_W      = 16;
    localparam int MS_W        = 6;
    localparam int TAB_W       = 15;

    localparam logic [RATE_W-1:0] RATE_RESET = 17'd48000;
    localparam logic [ROOM_W-1:0] ROOM_RESET = 10'd256;
    localparam logic [ROOM_W-1:0] ROOM_MIN   = 10'd26;
    localparam logic [ROOM_W-1:0] ROOM_MAX   = 10'd768;
    localparam logic [COEF_W-1:0] DAMP_RESET = 16'd9830;
    localparam logic [COEF_W-1:0] DAMP_MAX   = 16'd32440;
    localparam logic [COEF_W-1:0] WET_RESET  = 16'd9830;
    localparam logic [COEF_W-1:0] UNITY_Q15  = 16'd32768;

    // delay = (ms * rate * size + 128000) / 256000, done as >>11 then /125
    localparam logic [32:0] DELAY_BIAS  = 33'd128000;
    localparam int          DELAY_SHIFT = 11;
    localparam int          DELAY_DIV   = 125;
    localparam int          Y_W         = 22;
    localparam logic [Y_W-1:0] RECIP_DIV = 22'd2147484;  // ceil(2^28 / 125)
    localparam int          RECIP_SHIFT = 28;
    localparam int          Q_W         = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SAMPLE_RATE = 3'd0,
        CFG_ROOM_SIZE   = 3'd1,
        CFG_DAMPING     = 3'd2,
        CFG_WET_MIX     = 3'd3
    } cfg_reg_t;

    typedef struct packed {
        logic             load_in;
        logic             issue;
        logic [TAP_W-1:0] tap;
        logic             mix_mul;
        logic             out_load;
    } ser_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } ser_stat_t;

    function automatic logic [MS_W-1:0] tap_ms(input logic [TAP_W-1:0] t);
        logic [MS_W-1:0] v;
        unique case (t)
            3'd0:    v = 6'd7;
            3'd1:    v = 6'd11;
            3'd2:    v = 6'd17;
            3'd3:    v = 6'd23;
            3'd4:    v = 6'd29;
            3'd5:    v = 6'd37;
            3'd6:    v = 6'd43;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [TAB_W-1:0] tap_gain(input logic [TAP_W-1:0] t);
        logic [TAB_W-1:0] v;
        unique case (t)
            3'd0:    v = 15'd27853;
            3'd1:    v = 15'd23593;
            3'd2:    v = 15'd19661;
            3'd3:    v = 15'd16384;
            3'd4:    v = 15'd13763;
            3'd5:    v = 15'd11469;
            3'd6:    v = 15'd9175;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [TAB_W-1:0] pan_left(input logic [TAP_W-1:0] t);
        logic [TAB_W-1:0] v;
        unique case (t)
            3'd0:    v = 15'd29491;
            3'd1:    v = 15'd6554;
            3'd2:    v = 15'd22938;
            3'd3:    v = 15'd4915;
            3'd4:    v = 15'd24576;
            3'd5:    v = 15'd11469;
            3'd6:    v = 15'd26214;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [TAB_W-1:0] pan_right(input logic [TAP_W-1:0] t);
        logic [TAB_W-1:0] v;
        unique case (t)
            3'd0:    v = 15'd3277;
            3'd1:    v = 15'd26214;
            3'd2:    v = 15'd9830;
            3'd3:    v = 15'd27853;
            3'd4:    v = 15'd8192;
            3'd5:    v = 15'd21299;
            3'd6:    v = 15'd6554;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/ser_in_if.sv
// Input sample channel: one stereo pair per word, valid/ready handshake.
// Depends on ser_pkg.
interface ser_in_if import ser_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;

    modport source (output valid, output in_left, output in_right, input ready);
    modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

### rtl/core/ser_out_if.sv
// Output sample channel: one mixed stereo pair per word, valid/ready handshake.
// Depends on ser_pkg.
interface ser_out_if import ser_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;

    modport source (output valid, output out_left, output out_right, input ready);
    modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

### rtl/core/ser_cfg_if.sv
// Configuration write channel: register index plus write data, valid/ready handshake.
// Depends on ser_pkg.
interface ser_cfg_if import ser_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/ser_ctrl.sv
// Sequencer for the early-reflection block: accept, tap issue, drain, mix, output.
// Depends on ser_pkg; drives ser_datapath through ser_cmd_t.
module ser_ctrl import ser_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ser_stat_t stat,
    output ser_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAPS,
        S_DRAIN,
        S_MIX_MUL,
        S_MIX_OUT
    } state_t;

    state_t           state_reg;
    logic [TAP_W-1:0] tap_reg;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd.load_in  = in_ready && in_valid;
        cmd.issue    = (state_reg == S_TAPS);
        cmd.tap      = tap_reg;
        cmd.mix_mul  = (state_reg == S_MIX_MUL);
        cmd.out_load = (state_reg == S_MIX_OUT) && stat.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tap_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_TAPS;
                        tap_reg   <= '0;
                    end
                end
                S_TAPS:
                begin
                    if (tap_reg == TAP_W'(TAP_COUNT - 1))
                        state_reg <= S_DRAIN;
                    else
                        tap_reg <= tap_reg + 1'b1;
                end
                S_DRAIN:
                begin
                    if (!stat.pipe_busy)
                        state_reg <= S_MIX_MUL;
                end
                S_MIX_MUL:
                begin
                    state_reg <= S_MIX_OUT;
                end
                S_MIX_OUT:
                begin
                    if (stat.out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_first_tap_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> (cmd.issue && cmd.tap == '0))
        else $error("tap 0 not issued after accept");

    a_mix_on_empty_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mix_mul |-> !stat.pipe_busy)
        else $error("mix started with taps in flight");

    a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("output register overwritten");

endmodule

### rtl/core/ser_datapath.sv
// Datapath: config registers, history memory, per-tap delay/filter/gain/pan pipeline,
// wet accumulators, dry/wet mix and output register. Depends on ser_pkg.
module ser_datapath import ser_pkg::*; #(
    parameter int HISTORY_DEPTH = 8192
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ser_cmd_t                   cmd,
    output ser_stat_t                  stat,
    input  logic signed [SAMPLE_W-1:0] in_left,
    input  logic signed [SAMPLE_W-1:0] in_right,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic signed [SAMPLE_W-1:0] out_left,
    output logic signed [SAMPLE_W-1:0] out_right,
    input  logic                       cfg_valid,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    localparam int PTR_W     = $clog2(HISTORY_DEPTH);
    localparam int BIG_LIMIT = DELAY_DIV * HISTORY_DEPTH;
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(HISTORY_DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_W  = (PTR_W + 1)'(HISTORY_DEPTH);

    // config
    logic [RATE_W-1:0] rate_reg;
    logic [ROOM_W-1:0] room_reg;
    logic [COEF_W-1:0] damp_reg;
    logic [COEF_W-1:0] wet_reg;
    logic [26:0]       rs_reg;
    logic [COEF_W-1:0] a_reg;
    logic [COEF_W-1:0] dryc_reg;

    // history
    logic [SAMPLE_W-1:0] hist_mem [HISTORY_DEPTH];
    logic [PTR_W-1:0]    wp_reg;
    logic                full_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;

    // filter state
    logic signed [31:0] z_reg [TAP_COUNT];

    // stage valids and tap tags
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg;
    logic s6_v_reg, s7_v_reg, s8_v_reg, s9_v_reg, s10_v_reg;
    logic [TAP_W-1:0] s1_t_reg, s2_t_reg, s3_t_reg, s4_t_reg, s5_t_reg;
    logic [TAP_W-1:0] s6_t_reg, s7_t_reg, s8_t_reg, s9_t_reg;

    // stage payloads
    logic [Y_W-1:0]     y1_reg;
    logic               big2_reg;
    logic [43:0]        prod2_reg;
    logic [PTR_W-1:0]   d3_reg;
    logic               ok4_reg;
    logic signed [32:0] diff5_reg;
    logic signed [31:0] z5_reg;
    logic signed [49:0] prod6_reg;
    logic signed [31:0] z6_reg;
    logic signed [31:0] zn7_reg;
    logic signed [47:0] tvp8_reg;
    logic signed [23:0] tv9_reg;
    logic signed [39:0] pl10_reg;
    logic signed [39:0] pr10_reg;
    logic signed [41:0] wl_reg;
    logic signed [41:0] wr_reg;

    // mix
    logic signed [SAMPLE_W-1:0] xl_reg;
    logic signed [SAMPLE_W-1:0] xr_reg;
    logic signed [40:0]         dryl_reg;
    logic signed [40:0]         dryr_reg;
    logic signed [58:0]         wetl_reg;
    logic signed [58:0]         wetr_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_left_reg;
    logic signed [SAMPLE_W-1:0] out_right_reg;

    // combinational
    logic [24:0]         in_sum;
    logic [SAMPLE_W-1:0] mono;
    logic [32:0]         num;
    logic [Q_W-1:0]      q3;
    logic [PTR_W-1:0]    d_clamp;
    logic [PTR_W:0]      rp_wide;
    logic [PTR_W-1:0]    rd_addr;
    logic signed [31:0]  x5;
    logic signed [31:0]  z_cur;
    logic signed [49:0]  r7;
    logic signed [35:0]  zsum7;
    logic signed [31:0]  zn;
    logic signed [47:0]  r9;
    logic [COEF_W-1:0]   dmp;

    function automatic logic signed [SAMPLE_W-1:0] mix_round(
        input logic signed [40:0] dry,
        input logic signed [58:0] wet
    );
        logic signed [59:0] tot;
        logic signed [29:0] q;
        logic signed [SAMPLE_W-1:0] r;
        tot = {{4{dry[40]}}, dry, 15'd0} + {wet[58], wet} + 60'sd536870912;
        q   = tot[59:30];
        if (q > 30'sd8388607)
            r = 24'sh7FFFFF;
        else if (q < -30'sd8388608)
            r = 24'sh800000;
        else
            r = q[SAMPLE_W-1:0];
        return r;
    endfunction

    // half-sum, floor
    assign in_sum = {in_left[SAMPLE_W-1], in_left} + {in_right[SAMPLE_W-1], in_right};
    assign mono   = in_sum[24:1];

    assign num = {27'd0, tap_ms(cmd.tap)} * {6'd0, rs_reg} + DELAY_BIAS;
    assign dmp = (damp_reg > DAMP_MAX) ? DAMP_MAX : damp_reg;

    always_comb
    begin
        q3 = prod2_reg[RECIP_SHIFT +: Q_W];
        if (big2_reg || q3 > Q_W'(HISTORY_DEPTH - 1))
            d_clamp = LAST_IDX;
        else if (q3 == '0)
            d_clamp = PTR_W'(1);
        else
            d_clamp = q3[PTR_W-1:0];
    end

    always_comb
    begin
        if (wp_reg >= d3_reg)
            rp_wide = {1'b0, wp_reg - d3_reg};
        else
            rp_wide = {1'b0, wp_reg} + DEPTH_W - {1'b0, d3_reg};
        rd_addr = rp_wide[PTR_W-1:0];
    end

    always_comb
    begin
        x5    = ok4_reg ? $signed({rd_data_reg, 8'd0}) : 32'sd0;
        z_cur = z_reg[s4_t_reg];
        r7    = prod6_reg + 50'sd16384;
        zsum7 = {{4{z6_reg[31]}}, z6_reg} + {r7[49], r7[49:15]};
        if (zsum7 > 36'sd2147483647)
            zn = 32'sh7FFFFFFF;
        else if (zsum7 < -36'sd2147483648)
            zn = 32'sh80000000;
        else
            zn = zsum7[31:0];
        r9 = tvp8_reg + 48'sd4194304;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= RATE_RESET;
            room_reg      <= ROOM_RESET;
            damp_reg      <= DAMP_RESET;
            wet_reg       <= WET_RESET;
            wp_reg        <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            s4_v_reg      <= 1'b0;
            s5_v_reg      <= 1'b0;
            s6_v_reg      <= 1'b0;
            s7_v_reg      <= 1'b0;
            s8_v_reg      <= 1'b0;
            s9_v_reg      <= 1'b0;
            s10_v_reg     <= 1'b0;
            for (int i = 0; i < TAP_COUNT; i++)
                z_reg[i] <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_SAMPLE_RATE: rate_reg <= cfg_data[RATE_W-1:0];
                    CFG_ROOM_SIZE:
                    begin
                        if (cfg_data[ROOM_W-1:0] < ROOM_MIN)
                            room_reg <= ROOM_MIN;
                        else if (cfg_data[ROOM_W-1:0] > ROOM_MAX)
                            room_reg <= ROOM_MAX;
                        else
                            room_reg <= cfg_data[ROOM_W-1:0];
                    end
                    CFG_DAMPING: damp_reg <= cfg_data[COEF_W-1:0];
                    CFG_WET_MIX:
                    begin
                        if (cfg_data[COEF_W-1:0] > UNITY_Q15)
                            wet_reg <= UNITY_Q15;
                        else
                            wet_reg <= cfg_data[COEF_W-1:0];
                    end
                    default: ;
                endcase
            end

            s1_v_reg  <= cmd.issue;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            s5_v_reg  <= s4_v_reg;
            s6_v_reg  <= s5_v_reg;
            s7_v_reg  <= s6_v_reg;
            s8_v_reg  <= s7_v_reg;
            s9_v_reg  <= s8_v_reg;
            s10_v_reg <= s9_v_reg;

            if (s6_v_reg)
                z_reg[s6_t_reg] <= zn;

            if (cmd.out_load)
            begin
                if (wp_reg == LAST_IDX)
                begin
                    wp_reg   <= '0;
                    full_reg <= 1'b1;
                end
                else
                    wp_reg <= wp_reg + 1'b1;
            end

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // history memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            hist_mem[wp_reg] <= mono;
        if (s3_v_reg)
            rd_data_reg <= hist_mem[rd_addr];
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        rs_reg   <= rate_reg * {7'd0, room_reg};
        a_reg    <= COEF_W'({1'b0, UNITY_Q15} - {1'b0, dmp});
        dryc_reg <= UNITY_Q15 - wet_reg;

        s1_t_reg <= cmd.tap;
        y1_reg   <= num[DELAY_SHIFT +: Y_W];

        s2_t_reg  <= s1_t_reg;
        big2_reg  <= (y1_reg >= Y_W'(BIG_LIMIT));
        prod2_reg <= {22'd0, y1_reg} * {22'd0, RECIP_DIV};

        s3_t_reg <= s2_t_reg;
        d3_reg   <= d_clamp;

        s4_t_reg <= s3_t_reg;
        ok4_reg  <= full_reg || (rd_addr < wp_reg);

        s5_t_reg  <= s4_t_reg;
        diff5_reg <= {x5[31], x5} - {z_cur[31], z_cur};
        z5_reg    <= z_cur;

        s6_t_reg  <= s5_t_reg;
        prod6_reg <= $signed({1'b0, a_reg}) * diff5_reg;
        z6_reg    <= z5_reg;

        s7_t_reg <= s6_t_reg;
        zn7_reg  <= zn;

        s8_t_reg <= s7_t_reg;
        tvp8_reg <= zn7_reg * $signed({1'b0, tap_gain(s7_t_reg)});

        s9_t_reg <= s8_t_reg;
        tv9_reg  <= r9[46:23];

        pl10_reg <= tv9_reg * $signed({1'b0, pan_left(s9_t_reg)});
        pr10_reg <= tv9_reg * $signed({1'b0, pan_right(s9_t_reg)});

        if (cmd.load_in)
        begin
            wl_reg <= '0;
            wr_reg <= '0;
            xl_reg <= in_left;
            xr_reg <= in_right;
        end
        else if (s10_v_reg)
        begin
            wl_reg <= wl_reg + {{2{pl10_reg[39]}}, pl10_reg};
            wr_reg <= wr_reg + {{2{pr10_reg[39]}}, pr10_reg};
        end

        if (cmd.mix_mul)
        begin
            dryl_reg <= xl_reg * $signed({1'b0, dryc_reg});
            dryr_reg <= xr_reg * $signed({1'b0, dryc_reg});
            wetl_reg <= wl_reg * $signed({1'b0, wet_reg});
            wetr_reg <= wr_reg * $signed({1'b0, wet_reg});
        end

        if (cmd.out_load)
        begin
            out_left_reg  <= mix_round(dryl_reg, wetl_reg);
            out_right_reg <= mix_round(dryr_reg, wetr_reg);
        end
    end

    assign stat.pipe_busy = s1_v_reg | s2_v_reg | s3_v_reg | s4_v_reg | s5_v_reg
                          | s6_v_reg | s7_v_reg | s8_v_reg | s9_v_reg | s10_v_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;

    a_wp_moves_on_output: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.out_load |=> $stable(wp_reg))
        else $error("write pointer moved without an output");

    a_full_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |=> full_reg)
        else $error("history fill flag dropped");

    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> (wl_reg == '0 && wr_reg == '0))
        else $error("wet accumulators not cleared on accept");

endmodule

### rtl/core/stereo_early_reflections.sv
// Top level of the stereo early-reflection generator (seven-tap delay line).
// Depends on ser_pkg, ser_in_if, ser_out_if, ser_cfg_if, ser_ctrl, ser_datapath.
//
//  channel   | modport | word contents                 | handshake
//  ----------+---------+-------------------------------+-----------
//  samples   | sink    | in_left, in_right   (Q1.23)   | valid/ready
//  mixed     | source  | out_left, out_right (Q1.23)   | valid/ready
//  cfg       | sink    | index, data (register write)  | valid/ready, ready held high
//
// Each stereo word goes through these steps before the next accept: its accept,
// issue of its seven taps one after another into the shared delay/filter/gain/pan
// pipeline, drain of that pipeline into the wet accumulators, mix and output load.
// The history memory (one write and one read port) is read once per tap.
// Results sit in an output register; a new word is accepted while it waits. A stalled
// output only holds the final mix step until the register frees.
// Reset restores register defaults and clears filter state and the write pointer; no
// memory sweep runs: a fill flag makes history entries not yet written read as zero.
module stereo_early_reflections import ser_pkg::*; #(
    parameter int HISTORY_DEPTH = 8192
) (
    input  logic      clk,
    input  logic      rst_n,
    ser_in_if.sink    samples,
    ser_out_if.source mixed,
    ser_cfg_if.sink   cfg
);

    ser_cmd_t  cmd;   // sequencer commands
    ser_stat_t stat;  // pipeline / output slot status

    // cfg writes always taken; user keeps block idle whenever they arrive, unchecked
    assign cfg.ready = 1'b1;

    ser_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ser_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_left   (samples.in_left),
        .in_right  (samples.in_right),
        .out_ready (mixed.ready),
        .out_valid (mixed.valid),
        .out_left  (mixed.out_left),
        .out_right (mixed.out_right),
        .cfg_valid (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data)
    );

endmodule

### tb/tb_stereo_early_reflections.sv
// Self-checking testbench for stereo_early_reflections: drives stereo words and register writes,
// predicts every mixed word from its own model, and compares the results field by field.
// Depends on ser_pkg, ser_in_if, ser_out_if, ser_cfg_if and the stereo_early_reflections RTL.
module tb_stereo_early_reflections;
    import ser_pkg::*;

    // ------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------
    localparam int HIST_DEPTH   = 8192;
    localparam int Q15_ONE      = 32768;
    localparam int DAMP_LIMIT   = 32440;       // 0.99 in Q15
    localparam int DRAIN_CYCLES = 48;
    localparam int HOLD_CYCLES  = 400;         // long output stall
    localparam int REPORT_CAP   = 40;          // print cap, every mismatch still counts
    // watchdog limit in time units, well above the slowest legal run
    localparam longint LIMIT_TIME = 64'd4_800_000;

    // register indexes past the defined list; writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_FIRST = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
    } stereo_pair_t;

    localparam sample_t FULL_POS = 24'sh7FFFFF;
    localparam sample_t FULL_NEG = 24'sh800000;

    // reflection pattern: tap time in ms, gain and pan weights (Q15)
    localparam int     REFL_MS    [TAP_COUNT] = '{7, 11, 17, 23, 29, 37, 43};
    localparam longint REFL_GAIN  [TAP_COUNT] =
        '{27853, 23593, 19661, 16384, 13763, 11469, 9175};
    localparam longint REFL_PAN_L [TAP_COUNT] =
        '{29491, 6554, 22938, 4915, 24576, 11469, 26214};
    localparam longint REFL_PAN_R [TAP_COUNT] =
        '{3277, 26214, 9830, 27853, 8192, 21299, 6554};

    // ------------------------------------------------------------------
    // Clock, reset, channels, DUT
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    ser_in_if  samples_ch ();
    ser_out_if mixed_ch ();
    ser_cfg_if cfg_ch ();

    stereo_early_reflections #(
        .HISTORY_DEPTH (HIST_DEPTH)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .mixed   (mixed_ch),
        .cfg     (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    stereo_pair_t expected_mix_q [$];   // predicted words, oldest first
    int           mismatch_count = 0;
    int           send_idle_pct  = 0;   // per-cycle chance the sender holds back
    int           sink_idle_pct  = 0;   // per-cycle chance the receiver drops ready
    int           hold_cycles    = 0;   // forced receiver stall, counted down below

    // Predictor copy of the registers, held as the block holds them after the write
    int unsigned rate_reg  = RATE_RESET;
    int unsigned room_reg  = ROOM_RESET;
    int unsigned damp_reg  = DAMP_RESET;
    int unsigned wet_reg   = WET_RESET;

    // Predictor copy of the datapath state: mono ring, write pointer, tap filters
    int          hist_mono [HIST_DEPTH];
    int unsigned wr_ptr;
    int          lp_state  [TAP_COUNT];

    // ------------------------------------------------------------------
    // Reflection predictor
    // ------------------------------------------------------------------

    // floor((v + 2^(s-1)) / 2^s): round half up
    function automatic longint round_half_up(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic sample_t saturate24(input longint v);
        if (v > longint'(FULL_POS))
            return FULL_POS;
        if (v < longint'(FULL_NEG))
            return FULL_NEG;
        return sample_t'(v);
    endfunction

    // tap delay in samples: round(ms * rate * size/256 / 1000), clamped to the ring
    function automatic int unsigned reflection_delay(input int t);
        longint unsigned span;
        span = (longint'(REFL_MS[t]) * rate_reg * room_reg + 128000) / 256000;
        if (span < 1)
            span = 1;
        if (span > HIST_DEPTH - 1)
            span = HIST_DEPTH - 1;
        return int'(span);
    endfunction

    // One stereo word in, one mixed word out; advances the model state.
    function automatic stereo_pair_t reflect_and_mix(input sample_t in_l, input sample_t in_r);
        int           mono;
        int unsigned  rd;
        longint       coef;
        longint       share;
        longint       x;
        longint       z;
        longint       tap_val;
        longint       wet_l;
        longint       wet_r;
        stereo_pair_t res;

        mono = (int'(in_l) + int'(in_r)) >>> 1;        // floor of the half-sum
        hist_mono[wr_ptr] = mono;
        coef  = longint'(Q15_ONE) - longint'((damp_reg > DAMP_LIMIT) ? DAMP_LIMIT : damp_reg);
        share = longint'(wet_reg);
        wet_l = 0;
        wet_r = 0;

        for (int t = 0; t < TAP_COUNT; t++)
        begin
            rd = (wr_ptr + HIST_DEPTH - reflection_delay(t)) % HIST_DEPTH;
            x  = longint'(hist_mono[rd]) * 256;
            z  = longint'(lp_state[t]);
            z  = z + round_half_up(coef * (x - z), 15);
            if (z > 64'sd2147483647)
                z = 64'sd2147483647;
            if (z < -64'sd2147483648)
                z = -64'sd2147483648;
            lp_state[t] = int'(z);
            tap_val = round_half_up(z * REFL_GAIN[t], 23);
            wet_l += tap_val * REFL_PAN_L[t];
            wet_r += tap_val * REFL_PAN_R[t];
        end

        wr_ptr = (wr_ptr + 1) % HIST_DEPTH;

        res.left  = saturate24(round_half_up(longint'(in_l) * (Q15_ONE - share) * Q15_ONE
                                             + wet_l * share, 30));
        res.right = saturate24(round_half_up(longint'(in_r) * (Q15_ONE - share) * Q15_ONE
                                             + wet_r * share, 30));
        return res;
    endfunction

    // Register write as the block keeps it: masking to the field, then clamping.
    function automatic void track_register_write(input logic [CFG_INDEX_W-1:0] idx,
                                                 input logic [CFG_DATA_W-1:0]  value);
        int unsigned field;
        case (idx)
            CFG_SAMPLE_RATE:
                rate_reg = value;
            CFG_ROOM_SIZE:
            begin
                field = value[ROOM_W-1:0];
                if (field < ROOM_MIN)
                    field = ROOM_MIN;
                if (field > ROOM_MAX)
                    field = ROOM_MAX;
                room_reg = field;
            end
            CFG_DAMPING:
                damp_reg = value[COEF_W-1:0];
            CFG_WET_MIX:
            begin
                field = value[COEF_W-1:0];
                wet_reg = (field > UNITY_Q15) ? UNITY_Q15 : field;
            end
            default:
                ;   // indexes past the list do nothing
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input sample_t got, input sample_t want);
        if (mismatch_count < REPORT_CAP)
            $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_mixed_words
        stereo_pair_t want;
        if (rst_n && mixed_ch.valid && mixed_ch.ready)
        begin
            if (expected_mix_q.size() == 0)
            begin
                report_mismatch("word with none pending, left", mixed_ch.out_left, 'x);
            end
            else
            begin
                want = expected_mix_q.pop_front();
                if (mixed_ch.out_left !== want.left)
                    report_mismatch("out_left", mixed_ch.out_left, want.left);
                if (mixed_ch.out_right !== want.right)
                    report_mismatch("out_right", mixed_ch.out_right, want.right);
            end
        end
    end

    // Receiver: random ready, or a counted hold-off when one is requested.
    initial
    begin
        mixed_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                mixed_ch.ready <= 1'b0;
                hold_cycles    <= hold_cycles - 1;
            end
            else
            begin
                mixed_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Watchdog
    initial
    begin
        #(LIMIT_TIME);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers (all entered right after a rising edge)
    // ------------------------------------------------------------------

    // Offer one stereo word; valid stays high afterwards so back-to-back words
    // never drop and reassert valid in the same step.
    task automatic send_pair(input sample_t l, input sample_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            samples_ch.valid <= 1'b0;
            @(posedge clk);
        end
        samples_ch.valid    <= 1'b1;
        samples_ch.in_left  <= l;
        samples_ch.in_right <= r;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        expected_mix_q.push_back(reflect_and_mix(l, r));
    endtask

    // Stop offering, let every pending word come out, then give the pipe time to settle.
    task automatic drain_block();
        samples_ch.valid <= 1'b0;
        while (expected_mix_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0]  value);
        drain_block();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        track_register_write(idx, value);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] rate,
                                 input logic [CFG_DATA_W-1:0] room,
                                 input logic [CFG_DATA_W-1:0] damp,
                                 input logic [CFG_DATA_W-1:0] wet);
        write_register(CFG_SAMPLE_RATE, rate);
        write_register(CFG_ROOM_SIZE, room);
        write_register(CFG_DAMPING, damp);
        write_register(CFG_WET_MIX, wet);
    endtask

    // mostly full-range noise, some quiet signal, some rail values
    function automatic sample_t random_sample();
        int v;
        case ($urandom_range(9))
            0:
                return $urandom_range(1) ? FULL_POS : FULL_NEG;
            1, 2:
            begin
                v = int'($urandom_range(511)) - 256;
                return sample_t'(v);
            end
            default:
                return sample_t'($urandom());
        endcase
    endfunction

    task automatic send_random_words(input int count);
        for (int i = 0; i < count; i++)
            send_pair(random_sample(), random_sample());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Rails, rounding of the half-sum, and the register corner cases.
    task automatic test_directed_corners();
        // reset settings: zero, rails, mixed signs, odd half-sum both ways
        send_pair('0, '0);
        send_pair(FULL_POS, FULL_POS);
        send_pair(FULL_NEG, FULL_NEG);
        send_pair(FULL_POS, FULL_NEG);
        send_pair(FULL_NEG, FULL_POS);
        send_pair(-24'sd1, '0);
        send_pair(24'sd1, '0);

        // writes past the register list are dropped
        write_register(CFG_SPARE_FIRST, '1);
        write_register(CFG_SPARE_LAST, '1);

        // rate zero -> every tap clamps to one sample; room below minimum;
        // damping above one; wet above one.
        apply_setting(17'd0, 17'd5, 17'hFFFF, 17'hFFFF);
        repeat (6)
            send_pair(FULL_POS, FULL_POS);
        repeat (6)
            send_pair(FULL_NEG, FULL_NEG);

        // top rate, room field masked to 1023 then clamped to 768 -> the longer delays clamp at the ring end;
        // no damping, dry only
        apply_setting(17'h1FFFF, 17'h1FFFF, 17'd0, 17'd0);
        send_random_words(4);
    endtask

    // Fixed settings at and around the register limits.
    task automatic test_register_extremes();
        logic [CFG_DATA_W-1:0] corner [8][4];
        corner = '{
            '{17'd8000,   17'd26,   17'd0,     17'd0},
            '{17'd96000,  17'd768,  17'd32768, 17'd32768},
            '{17'd8000,   17'd768,  17'd32440, 17'd16384},
            '{17'd96000,  17'd26,   17'd32441, 17'd32767},
            '{17'd0,      17'd1024, 17'd9830,  17'd32768},
            '{17'd1,      17'd1023, 17'd1,     17'd1},
            '{17'd131071, 17'd300,  17'd65535, 17'd40000},
            '{17'd48000,  17'd256,  17'd9830,  17'd9830}
        };
        foreach (corner[k])
        begin
            apply_setting(corner[k][0], corner[k][1], corner[k][2], corner[k][3]);
            send_random_words(40);
        end
    endtask

    // Random settings; now and then the whole 17-bit data word is random.
    task automatic test_random_settings();
        logic [CFG_DATA_W-1:0] rate;
        logic [CFG_DATA_W-1:0] room;
        logic [CFG_DATA_W-1:0] damp;
        logic [CFG_DATA_W-1:0] wet;
        for (int k = 0; k < 8; k++)
        begin
            rate = $urandom_range(3) == 0 ? $urandom() : $urandom_range(96000, 8000);
            room = $urandom_range(3) == 0 ? $urandom() : $urandom_range(768, 26);
            damp = $urandom_range(3) == 0 ? $urandom() : $urandom_range(32768);
            wet  = $urandom_range(3) == 0 ? $urandom() : $urandom_range(32768);
            apply_setting(rate, room, damp, wet);
            send_random_words(70);
        end
    endtask

    // Long unbroken streams so taps read history written many words ago.
    task automatic test_long_history();
        apply_setting(17'd48000, 17'd26, 17'd9830, 17'd16384);
        send_random_words(350);
        apply_setting(17'd16000, 17'd512, 17'd4000, 17'd24000);
        send_random_words(350);
    endtask

    // Receiver stalls for a long stretch while words keep coming: the block
    // fills its output register and in-flight word and must hold off input.
    task automatic test_output_backpressure();
        drain_block();
        hold_cycles <= HOLD_CYCLES;
        send_random_words(60);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n               <= 1'b0;
        samples_ch.valid    <= 1'b0;
        samples_ch.in_left  <= '0;
        samples_ch.in_right <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= '0;
        cfg_ch.data         <= '0;
        wr_ptr               = 0;

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        repeat (2)
            @(posedge clk);

        // sender mostly busy, receiver mostly stalled
        send_idle_pct = 12;
        sink_idle_pct <= 86;
        test_directed_corners();
        test_register_extremes();

        // sender mostly idle, receiver mostly ready
        send_idle_pct = 86;
        sink_idle_pct <= 12;
        test_random_settings();

        // no idling on either side
        send_idle_pct = 0;
        sink_idle_pct <= 0;
        test_long_history();
        test_output_backpressure();

        drain_block();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
rtl/core/ser_pkg.sv
rtl/core/ser_in_if.sv
rtl/core/ser_out_if.sv
rtl/core/ser_cfg_if.sv
rtl/core/ser_ctrl.sv
rtl/core/ser_datapath.sv
rtl/core/stereo_early_reflections.sv
tb/tb_stereo_early_reflections.sv
